// ===== src/aet_pkg.sv =====
// Shared types and constants of the arithmetic expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package aet_pkg;

  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_PAREN    = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  localparam logic [30:0] OP_ADD    = 31'd0;
  localparam logic [30:0] OP_SUB    = 31'd1;
  localparam logic [30:0] OP_MUL    = 31'd2;
  localparam logic [30:0] OP_DIV    = 31'd3;
  localparam logic [30:0] PAREN_LEFT  = 31'd0;
  localparam logic [30:0] PAREN_RIGHT = 31'd1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int GROUP_SIZE  = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] value;
  } token_t;

  // Tokens caused by one character, in output order.
  typedef struct packed {
    logic [1:0]                  count;
    token_t [GROUP_SIZE-1:0]     tok;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ===== src/aet_in_if.sv =====
// Character input channel.
`timescale 1ns / 1ps
`default_nettype none
interface aet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface
`default_nettype wire

// ===== src/aet_out_if.sv =====
// Token output channel.
`timescale 1ns / 1ps
`default_nettype none
interface aet_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [30:0] token_value;
  logic        last_result;

  modport source (output valid, token_kind, token_value, last_result, input ready);
  modport sink (input valid, token_kind, token_value, last_result, output ready);
endinterface
`default_nettype wire

// ===== src/aet_front.sv =====
// Front end: classifies characters, accumulates numbers, builds token groups.
`timescale 1ns / 1ps
`default_nettype none
module aet_front (
  input  logic                clk,
  input  logic                rst,
  aet_in_if.sink              char_in,
  input  aet_pkg::queue_stat_t q_stat,
  output logic                push,
  output aet_pkg::group_t     push_group
);
  import aet_pkg::*;

  logic        in_number;
  logic [30:0] acc;
  logic        halted;
  logic        in_number_next;
  logic [30:0] acc_next;
  logic        halted_next;

  logic        accept;
  logic [7:0]  ch;
  logic        eot;
  logic        is_digit;
  logic        is_ws;
  logic [3:0]  digit;
  logic [34:0] acc_x10;
  logic [30:0] acc_sat;
  token_t      chr_tok;
  token_t      cand [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] cand_on;
  logic [1:0]  n;

  assign ch      = char_in.char_code;
  assign eot     = char_in.end_of_text;
  assign accept  = char_in.valid && char_in.ready;
  assign char_in.ready = !q_stat.full;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign digit    = ch[3:0];

  // value*10 + digit as two shifted adds, then clamp
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, digit};
  assign acc_sat = (acc_x10 > {4'd0, NUM_MAX}) ? NUM_MAX : acc_x10[30:0];

  always_comb begin
    chr_tok.kind  = KIND_ERROR;
    chr_tok.value = '0;
    unique case (ch)
      CH_PLUS:   begin chr_tok.kind = KIND_OPERATOR; chr_tok.value = OP_ADD; end
      CH_MINUS:  begin chr_tok.kind = KIND_OPERATOR; chr_tok.value = OP_SUB; end
      CH_STAR:   begin chr_tok.kind = KIND_OPERATOR; chr_tok.value = OP_MUL; end
      CH_SLASH:  begin chr_tok.kind = KIND_OPERATOR; chr_tok.value = OP_DIV; end
      CH_LPAREN: begin chr_tok.kind = KIND_PAREN; chr_tok.value = PAREN_LEFT; end
      CH_RPAREN: begin chr_tok.kind = KIND_PAREN; chr_tok.value = PAREN_RIGHT; end
      default:   begin chr_tok.kind = KIND_ERROR; chr_tok.value = '0; end
    endcase
  end

  always_comb begin
    // pending number first, then the character's own token, then the end marker
    cand[0].kind  = KIND_NUMBER;
    cand[0].value = is_digit ? acc_sat : acc;
    cand_on[0]    = !halted && ((!is_digit && in_number) || (is_digit && eot));
    cand[1]       = chr_tok;
    cand_on[1]    = !halted && !is_digit && !is_ws;
    cand[2].kind  = KIND_END;
    cand[2].value = '0;
    cand_on[2]    = eot;

    push_group = '0;
    n = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (cand_on[i]) begin
        push_group.tok[n] = cand[i];
        n = n + 2'd1;
      end
    end
    push_group.count = n;
    push = accept && (n != 2'd0);
  end

  always_comb begin
    in_number_next = in_number;
    acc_next       = acc;
    halted_next    = halted;
    if (eot) begin
      in_number_next = 1'b0;
      acc_next       = '0;
      halted_next    = 1'b0;
    end else if (!halted) begin
      if (is_digit) begin
        in_number_next = 1'b1;
        acc_next       = acc_sat;
      end else begin
        in_number_next = 1'b0;
        acc_next       = '0;
        halted_next    = cand_on[1] && (chr_tok.kind == KIND_ERROR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number <= 1'b0;
      acc       <= '0;
      halted    <= 1'b0;
    end else if (accept) begin
      in_number <= in_number_next;
      acc       <= acc_next;
      halted    <= halted_next;
    end
  end

`ifndef SYNTH
  a_halt_no_number: assert property (@(posedge clk) disable iff (rst)
    halted |-> (!in_number && (acc == '0)))
    else $error("number pending while halted on error");
  a_end_closes_group: assert property (@(posedge clk) disable iff (rst)
    (accept && eot) |-> (push && (push_group.tok[push_group.count - 2'd1].kind == KIND_END)))
    else $error("end of text without end token last");
`endif

endmodule
`default_nettype wire

// ===== src/aet_queue.sv =====
// Short queue of token groups between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module aet_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  aet_pkg::group_t      push_group,
  input  logic                 pop,
  output aet_pkg::queue_stat_t q_stat,
  output aet_pkg::group_t      head
);
  import aet_pkg::*;

  group_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_stat.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== src/aet_back.sv =====
// Back end: walks the head group one token per transfer into the output register.
`timescale 1ns / 1ps
`default_nettype none
module aet_back (
  input  logic                 clk,
  input  logic                 rst,
  input  aet_pkg::queue_stat_t q_stat,
  input  aet_pkg::group_t      head,
  output logic                 pop,
  aet_out_if.source            token_out
);
  import aet_pkg::*;

  logic       out_valid;
  token_t     out_tok;
  logic       out_last;
  logic [1:0] idx;
  logic       load;
  logic       group_done;

  assign load       = !q_stat.empty && (!out_valid || token_out.ready);
  assign group_done = (idx == (head.count - 2'd1));
  assign pop        = load && group_done;

  assign token_out.valid       = out_valid;
  assign token_out.token_kind  = out_tok.kind;
  assign token_out.token_value = out_tok.value;
  assign token_out.last_result = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= group_done ? 2'd0 : idx + 2'd1;
      end else if (token_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= head.tok[idx];
      out_last <= group_done;
    end
  end

`ifndef SYNTH
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (idx < head.count))
    else $error("token index beyond head group");
  a_idx_rewinds: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0))
    else $error("token index not rewound after group");
`endif

endmodule
`default_nettype wire

// ===== src/arithmetic_expression_tokenizer.sv =====
// Top level of the arithmetic expression tokenizer.
// Path: a character's tokens are written into the queue, then into the output register.
// Throughput: one character per cycle while the queue is not full; the output register
// sends one token per cycle unless token_out.ready holds it, and a four-group queue
// between front and back end holds groups of up to 3 tokens each.
// Reset (synchronous, active high) clears lexer state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module arithmetic_expression_tokenizer (
  input  logic       clk,
  input  logic       rst,
  aet_in_if.sink     char_in,
  aet_out_if.source  token_out
);
  import aet_pkg::*;

  queue_stat_t q_stat;
  logic        push;
  group_t      push_group;
  logic        pop;
  group_t      head;

  aet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_group (push_group)
  );

  aet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  aet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .token_out (token_out)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench of the arithmetic expression tokenizer.
`timescale 1ns / 1ps
module tb;
  import aet_pkg::*;

  localparam int RANDOM_ITEMS = 405;
  localparam int CALM_ITEMS   = 60;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 150;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] value;
    logic        last;
  } token_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [1:0] n;
    token_rec_t t0;
    token_rec_t t1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aet_in_if  char_ch ();
  aet_out_if token_ch ();

  arithmetic_expression_tokenizer DUT (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .token_out(token_ch)
  );

  always #5 clk = ~clk;

  // lexer state mirrored on the testbench side
  logic        num_open;
  logic [30:0] num_acc;
  logic        halted;

  token_rec_t burst[$];
  token_rec_t pending_tokens[$];
  dir_row_t   dir_rows[$];

  int  mismatches  = 0;
  int  tokens_seen = 0;
  int  idle_cycles = 0;
  int  src_idle_pct = 20;
  bit  calm = 1'b0;

  function automatic void add_token(input logic [2:0] kind, input logic [30:0] value);
    burst.push_back({kind, value, 1'b0});
  endfunction

  function automatic void flush_number();
    if (num_open) begin
      add_token(KIND_NUMBER, num_acc);
      num_open = 1'b0;
      num_acc  = '0;
    end
  endfunction

  // Advance the mirrored state by one character; queue its tokens when keep is set.
  function automatic void lex_char(input logic [7:0] ch, input logic eot, input bit keep);
    logic [34:0] grown;
    token_rec_t  rec;
    burst.delete();
    if (!halted) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        grown    = {4'b0, num_acc} * 35'd10 + {27'b0, ch - CH_ZERO};
        num_acc  = (grown > {4'b0, NUM_MAX}) ? NUM_MAX : grown[30:0];
        num_open = 1'b1;
      end else begin
        flush_number();
        if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
          // whitespace only separates
        end else begin
          case (ch)
            CH_PLUS:   add_token(KIND_OPERATOR, OP_ADD);
            CH_MINUS:  add_token(KIND_OPERATOR, OP_SUB);
            CH_STAR:   add_token(KIND_OPERATOR, OP_MUL);
            CH_SLASH:  add_token(KIND_OPERATOR, OP_DIV);
            CH_LPAREN: add_token(KIND_PAREN, PAREN_LEFT);
            CH_RPAREN: add_token(KIND_PAREN, PAREN_RIGHT);
            default: begin
              add_token(KIND_ERROR, 31'd0);
              halted = 1'b1;
            end
          endcase
        end
      end
    end
    if (eot) begin
      flush_number();
      add_token(KIND_END, 31'd0);
      num_open = 1'b0;
      num_acc  = '0;
      halted   = 1'b0;
    end
    if (keep) begin
      foreach (burst[i]) begin
        rec      = burst[i];
        rec.last = (i == burst.size() - 1);
        pending_tokens.push_back(rec);
      end
    end
  endfunction

  function automatic dir_row_t row(input logic [7:0] ch, input logic eot, input logic typed,
                                   input logic [1:0] n,
                                   input logic [2:0] k0, input logic [30:0] v0,
                                   input logic [2:0] k1, input logic [30:0] v1);
    return {ch, eot, typed, n, {k0, v0, n == 2'd1}, {k1, v1, n == 2'd2}};
  endfunction

  // Offer one character, with an optional gap first; return at the edge it transfers.
  task automatic send_char(input logic [7:0] ch, input logic eot);
    int gap;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      char_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_ch.valid       <= 1'b1;
    char_ch.char_code   <= ch;
    char_ch.end_of_text <= eot;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t   cur;
    logic [7:0] text[$];
    logic [7:0] ch;
    int         len;
    int         ndig;
    int         random_items;
    bit         noise_text;
    bit         all_nines;
    char_ch.valid       = 1'b0;
    char_ch.char_code   = 8'd0;
    char_ch.end_of_text = 1'b0;
    num_open = 1'b0;
    num_acc  = '0;
    halted   = 1'b0;
    random_items = 0;

    dir_rows.push_back(row(CH_PLUS,   1'b0, 1'b1, 2'd1, KIND_OPERATOR, OP_ADD, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_MINUS,  1'b0, 1'b1, 2'd1, KIND_OPERATOR, OP_SUB, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_STAR,   1'b0, 1'b1, 2'd1, KIND_OPERATOR, OP_MUL, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_SLASH,  1'b0, 1'b1, 2'd1, KIND_OPERATOR, OP_DIV, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_LPAREN, 1'b0, 1'b1, 2'd1, KIND_PAREN, PAREN_LEFT, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_RPAREN, 1'b0, 1'b1, 2'd1, KIND_PAREN, PAREN_RIGHT, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_ZERO,   1'b0, 1'b1, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_NINE,   1'b0, 1'b1, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_TAB,    1'b0, 1'b0, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_ZERO + 8'd7, 1'b0, 1'b0, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_SPACE,  1'b1, 1'b0, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    // ten nines overflow the accumulator
    repeat (10) dir_rows.push_back(row(CH_NINE, 1'b0, 1'b0, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b1, 2'd2, KIND_NUMBER, NUM_MAX, KIND_ERROR, 0));
    dir_rows.push_back(row(8'h80, 1'b0, 1'b1, 2'd0, KIND_NUMBER, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(CH_RPAREN, 1'b1, 1'b1, 2'd1, KIND_END, 0, KIND_NUMBER, 0));
    dir_rows.push_back(row(8'hFF, 1'b1, 1'b1, 2'd2, KIND_ERROR, 0, KIND_END, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      cur = dir_rows[i];
      send_char(cur.ch, cur.eot);
      lex_char(cur.ch, cur.eot, !cur.typed);
      if (cur.typed && cur.n != 2'd0) pending_tokens.push_back(cur.t0);
      if (cur.typed && cur.n == 2'd2) pending_tokens.push_back(cur.t1);
    end

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 10;
        default: src_idle_pct = 40;
      endcase
      text.delete();
      len        = $urandom_range(1, 18);
      noise_text = ($urandom_range(0, 9) == 0);
      while (text.size() < len) begin
        if (noise_text) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:39]: begin
              ndig      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                                      : $urandom_range(1, 4);
              all_nines = $urandom_range(0, 1);
              repeat (ndig)
                text.push_back(all_nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
            end
            [40:64]: begin
              case ($urandom_range(0, 3))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                2: text.push_back(CH_STAR);
                default: text.push_back(CH_SLASH);
              endcase
            end
            [65:79]: text.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
            [80:94]: begin
              ndig = $urandom_range(0, 5);
              text.push_back(ndig == 5 ? CH_SPACE : CH_TAB + 8'(ndig));
            end
            default: begin
              // any byte the lexer does not know
              ch = 8'($urandom_range(0, 255));
              while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_SPACE ||
                     (ch >= CH_TAB && ch <= CH_CR) || ch == CH_PLUS || ch == CH_MINUS ||
                     ch == CH_STAR || ch == CH_SLASH || ch == CH_LPAREN || ch == CH_RPAREN)
                ch = 8'($urandom_range(0, 255));
              text.push_back(ch);
            end
          endcase
        end
      end
      foreach (text[i]) begin
        send_char(text[i], i == text.size() - 1);
        random_items++;
        lex_char(text[i], i == text.size() - 1, 1'b1);
        if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      end
    end

    @(negedge clk);
    char_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS arithmetic_expression_tokenizer");
    else
      $display("FAIL arithmetic_expression_tokenizer");
    $finish;
  end

  // Token receiver: random stall bursts and one long hold-off to back up the queue.
  initial begin : token_sink
    int stall;
    int sink_idle_pct;
    bit held;
    stall         = 0;
    sink_idle_pct = 20;
    held          = 1'b0;
    token_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) sink_idle_pct = $urandom_range(0, 2) * 20;
      if (!held && tokens_seen >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && $urandom_range(0, 99) < sink_idle_pct) begin
        stall = $urandom_range(1, 15);
      end
      if (stall > 0) begin
        token_ch.ready <= 1'b0;
        stall--;
      end else begin
        token_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    token_rec_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token kind %0d value %0d last %0b", $time,
                 token_ch.token_kind, token_ch.token_value, token_ch.last_result);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_ch.token_kind !== want.kind) begin
          $display("%0t: token_kind expected %0d actual %0d", $time, want.kind,
                   token_ch.token_kind);
          mismatches++;
        end
        if (token_ch.token_value !== want.value) begin
          $display("%0t: token_value expected %0d actual %0d", $time, want.value,
                   token_ch.token_value);
          mismatches++;
        end
        if (token_ch.last_result !== want.last) begin
          $display("%0t: last_result expected %0b actual %0b", $time, want.last,
                   token_ch.last_result);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (token_ch.valid && token_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL arithmetic_expression_tokenizer");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
src/aet_pkg.sv
src/aet_in_if.sv
src/aet_out_if.sv
src/aet_front.sv
src/aet_queue.sv
src/aet_back.sv
src/arithmetic_expression_tokenizer.sv
test/tb.sv
